// ===== rtl/patan_pkg.sv =====
// patan_pkg: shared types and fixed-point constants for the atan2 pipeline
// no dependencies; imported by every rtl module of the block

`default_nettype none

package patan_pkg;

    // fraction bits of the internal ratio and polynomial terms
    localparam int FRAC_BITS = 16;
    // ratio lo/hi in Q1.16, 0 .. 65536
    localparam int RATIO_W = FRAC_BITS + 1;
    // product width used by every rounded multiply
    localparam int PROD_W = 34;
    // widths of the horner terms
    localparam int T1_W = 14;
    localparam int T3_W = 15;
    // folded angle before scaling, Q2.16 up to pi
    localparam int FOLD_W = 18;
    localparam int ANGLE_W = 16;
    localparam int QANG_W = 15;

    // quotient bits resolved in each divider stage
    localparam int DIV_STEP = 2;
    localparam int DIV_STAGES = (RATIO_W + DIV_STEP - 1) / DIV_STEP;

    localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

    localparam logic [RATIO_W-1:0] C7_Q16 = 17'd3047;
    localparam logic [RATIO_W-1:0] C5_Q16 = 17'd10441;
    localparam logic [RATIO_W-1:0] C3_Q16 = 17'd21471;
    localparam logic [RATIO_W-1:0] HALF_PI_Q16 = 17'd102944;
    localparam logic [FOLD_W-1:0] PI_Q16 = 18'd205887;
    localparam logic [FOLD_W:0] Q13_RND = 19'd4;

    // octant / quadrant bookkeeping that rides along with each request
    typedef struct packed {
        logic zero;
        logic swap;
        logic xneg;
        logic yneg;
    } patan_flags_t;

endpackage

`default_nettype wire

// ===== rtl/polynomial_atan2.sv =====
// polynomial_atan2: four-quadrant arctangent, top level of the pipeline
// depends on patan_pkg, patan_div, patan_poly, patan_fold
//
//   channel   signals                           direction  width
//   request   in_valid, in_stall, y_coord,      in         COORD_WIDTH each coord
//             x_coord
//   result    out_valid, out_stall, angle       out        16, radians * 8192
//
// the pipeline has one prep stage, ceil(17/2) = 9 divider stages at two
// quotient bits each, five multiply stages of the horner chain, one fold stage
// sustained rate is one request per cycle while out_stall is low; every stage holds one request
// rst_n clears only the valid bits, data registers are left as they are
// a stall on the result side lets bubbles collapse first, so in_stall only
// rises once every stage is full and the result is being held

`default_nettype none

module polynomial_atan2 #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [COORD_WIDTH-1:0]        y_coord,
    input  wire logic [COORD_WIDTH-1:0]        x_coord,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [patan_pkg::ANGLE_W-1:0]      angle
);
    import patan_pkg::*;

    // divider to polynomial
    logic               div_valid;
    logic               div_stall;
    logic [RATIO_W-1:0] div_ratio;
    patan_flags_t       div_flags;

    // polynomial to fold
    logic               poly_valid;
    logic               poly_stall;
    logic [RATIO_W-1:0] poly_val;
    patan_flags_t       poly_flags;

    // ratio = round(min * 2^16 / max), octant flags ride along
    patan_div #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .y_coord   (y_coord),
        .x_coord   (x_coord),
        .out_valid (div_valid),
        .out_stall (div_stall),
        .ratio     (div_ratio),
        .flags     (div_flags)
    );

    // a - c3 a^3 + c5 a^5 - c7 a^7, one multiply per stage
    patan_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_stall  (div_stall),
        .ratio     (div_ratio),
        .in_flags  (div_flags),
        .out_valid (poly_valid),
        .out_stall (poly_stall),
        .poly      (poly_val),
        .out_flags (poly_flags)
    );

    // reflect around pi/2 and pi, round to q2.13, apply the sign of y
    patan_fold u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (poly_valid),
        .in_stall  (poly_stall),
        .poly      (poly_val),
        .flags     (poly_flags),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .angle     (angle)
    );

`ifndef SYNTHESIS
    // the angle never leaves [-pi, pi] in q2.13
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(angle) <= 16'sd25736) && ($signed(angle) >= -16'sd25736))
        else $error("angle outside [-pi, pi]");

    // back pressure reaches the request side only through a held result
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("request stalled without a held result");

    // a held result is still there in the next cycle
    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("held result dropped");
`endif

endmodule

`default_nettype wire

// ===== rtl/patan_div.sv =====
// patan_div: magnitude, octant sort and pipelined restoring divide of min by max
// depends on patan_pkg

`default_nettype none

module patan_div #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [COORD_WIDTH-1:0]        y_coord,
    input  wire logic [COORD_WIDTH-1:0]        x_coord,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [patan_pkg::RATIO_W-1:0]      ratio,
    output patan_pkg::patan_flags_t            flags
);
    import patan_pkg::*;

    localparam int W = COORD_WIDTH;
    localparam int NW = COORD_WIDTH + FRAC_BITS + 1;
    localparam int NSTG = DIV_STAGES + 1;

    logic                v_reg    [NSTG];
    logic [W-1:0]        rem_reg  [NSTG];
    logic [RATIO_W-1:0]  num_reg  [NSTG];
    logic [RATIO_W-1:0]  quo_reg  [NSTG];
    logic [W-1:0]        hi_reg   [NSTG];
    patan_flags_t        flg_reg  [NSTG];

    logic [W-1:0]        rem_next [NSTG];
    logic [RATIO_W-1:0]  num_next [NSTG];
    logic [RATIO_W-1:0]  quo_next [NSTG];
    logic                en       [NSTG+1];

    // prep: magnitudes, sort, rounded numerator
    logic [W-1:0]  ay, ax, lo, hi;
    logic [NW-1:0] numer;
    patan_flags_t  flg_prep;

    always_comb
    begin
        flg_prep.yneg = y_coord[W-1];
        flg_prep.xneg = x_coord[W-1];
        ay = flg_prep.yneg ? (~y_coord + W'(1)) : y_coord;
        ax = flg_prep.xneg ? (~x_coord + W'(1)) : x_coord;
        flg_prep.swap = ay > ax;
        flg_prep.zero = (ay == '0) && (ax == '0);
        lo = flg_prep.swap ? ax : ay;
        hi = flg_prep.swap ? ay : ax;
        numer = (NW'(lo) << FRAC_BITS) + NW'(hi >> 1);
        rem_next[0] = numer[NW-1:RATIO_W];
        num_next[0] = numer[RATIO_W-1:0];
        quo_next[0] = '0;
    end

    // bubble-collapsing handshake down the chain
    assign en[NSTG] = !out_stall;
    genvar gi;
    generate
        for (gi = 0; gi < NSTG; gi++)
        begin : g_en
            assign en[gi] = !v_reg[gi] || en[gi+1];
        end
    endgenerate
    assign in_stall = !en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en[0])
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0] && in_valid)
        begin
            rem_reg[0] <= rem_next[0];
            num_reg[0] <= num_next[0];
            quo_reg[0] <= quo_next[0];
            hi_reg[0]  <= hi;
            flg_reg[0] <= flg_prep;
        end
    end

    generate
        for (gi = 1; gi < NSTG; gi++)
        begin : g_stage
            always_comb
            begin
                logic [W:0]         sh;
                logic [W:0]         diff;
                logic [W-1:0]       rem;
                logic [RATIO_W-1:0] num;
                logic [RATIO_W-1:0] quo;
                sh = '0;
                diff = '0;
                rem = rem_reg[gi-1];
                num = num_reg[gi-1];
                quo = quo_reg[gi-1];
                for (int j = 0; j < DIV_STEP; j++)
                begin
                    if ((gi - 1) * DIV_STEP + j < RATIO_W)
                    begin
                        sh = {rem, num[RATIO_W-1]};
                        num = {num[RATIO_W-2:0], 1'b0};
                        diff = sh - {1'b0, hi_reg[gi-1]};
                        if (sh >= {1'b0, hi_reg[gi-1]})
                        begin
                            rem = diff[W-1:0];
                            quo = {quo[RATIO_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem = sh[W-1:0];
                            quo = {quo[RATIO_W-2:0], 1'b0};
                        end
                    end
                end
                rem_next[gi] = rem;
                num_next[gi] = num;
                quo_next[gi] = quo;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[gi] <= 1'b0;
                end
                else if (en[gi])
                begin
                    v_reg[gi] <= v_reg[gi-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[gi] && v_reg[gi-1])
                begin
                    rem_reg[gi] <= rem_next[gi];
                    num_reg[gi] <= num_next[gi];
                    quo_reg[gi] <= quo_next[gi];
                    hi_reg[gi]  <= hi_reg[gi-1];
                    flg_reg[gi] <= flg_reg[gi-1];
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[NSTG-1];
    assign ratio     = quo_reg[NSTG-1];
    assign flags     = flg_reg[NSTG-1];

endmodule

`default_nettype wire

// ===== rtl/patan_poly.sv =====
// patan_poly: five-stage horner evaluation of the odd arctangent polynomial
// depends on patan_pkg

`default_nettype none

module patan_poly (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [patan_pkg::RATIO_W-1:0] ratio,
    input  wire patan_pkg::patan_flags_t       in_flags,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [patan_pkg::RATIO_W-1:0]      poly,
    output patan_pkg::patan_flags_t            out_flags
);
    import patan_pkg::*;

    localparam int NSTG = 5;

    logic               v_reg   [NSTG];
    logic               en      [NSTG+1];
    logic [RATIO_W-1:0] a_reg   [NSTG];
    patan_flags_t       flg_reg [NSTG];

    logic [RATIO_W-1:0] s1_reg, s2_reg, s3_reg;
    logic [T1_W-1:0]    t1_reg;
    logic [T3_W-1:0]    t3_reg;
    logic [T3_W-1:0]    p_reg;
    logic [RATIO_W-1:0] r_reg;

    logic [PROD_W-1:0]  prod1, prod2, prod3, prod4, prod5;
    logic [RATIO_W-1:0] s1_next, t1_full, t3_full, r_full;
    logic [T1_W-1:0]    t1_next;
    logic [T3_W-1:0]    t3_next, p_next;

    assign en[NSTG] = !out_stall;
    genvar gi;
    generate
        for (gi = 0; gi < NSTG; gi++)
        begin : g_en
            assign en[gi] = !v_reg[gi] || en[gi+1];
        end
    endgenerate
    assign in_stall = !en[0];

    always_comb
    begin
        // s = a^2
        prod1 = PROD_W'(ratio) * PROD_W'(ratio) + RND_HALF;
        s1_next = prod1[FRAC_BITS+RATIO_W-1:FRAC_BITS];
        // t1 = c5 - c7 s
        prod2 = PROD_W'(C7_Q16) * PROD_W'(s1_reg) + RND_HALF;
        t1_full = C5_Q16 - prod2[FRAC_BITS+RATIO_W-1:FRAC_BITS];
        t1_next = t1_full[T1_W-1:0];
        // t3 = c3 - t1 s
        prod3 = PROD_W'(t1_reg) * PROD_W'(s2_reg) + RND_HALF;
        t3_full = C3_Q16 - prod3[FRAC_BITS+RATIO_W-1:FRAC_BITS];
        t3_next = t3_full[T3_W-1:0];
        // p = t3 s
        prod4 = PROD_W'(t3_reg) * PROD_W'(s3_reg) + RND_HALF;
        p_next = prod4[FRAC_BITS+T3_W-1:FRAC_BITS];
        // r = a - p a
        prod5 = PROD_W'(p_reg) * PROD_W'(a_reg[3]) + RND_HALF;
        r_full = a_reg[3] - prod5[FRAC_BITS+RATIO_W-1:FRAC_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0] && in_valid)
        begin
            a_reg[0]   <= ratio;
            flg_reg[0] <= in_flags;
            s1_reg     <= s1_next;
        end
        if (en[1] && v_reg[0])
        begin
            a_reg[1]   <= a_reg[0];
            flg_reg[1] <= flg_reg[0];
            s2_reg     <= s1_reg;
            t1_reg     <= t1_next;
        end
        if (en[2] && v_reg[1])
        begin
            a_reg[2]   <= a_reg[1];
            flg_reg[2] <= flg_reg[1];
            s3_reg     <= s2_reg;
            t3_reg     <= t3_next;
        end
        if (en[3] && v_reg[2])
        begin
            a_reg[3]   <= a_reg[2];
            flg_reg[3] <= flg_reg[2];
            p_reg      <= p_next;
        end
        if (en[4] && v_reg[3])
        begin
            a_reg[4]   <= a_reg[3];
            flg_reg[4] <= flg_reg[3];
            r_reg      <= r_full;
        end
    end

    assign out_valid = v_reg[NSTG-1];
    assign poly      = r_reg;
    assign out_flags = flg_reg[NSTG-1];

endmodule

`default_nettype wire

// ===== rtl/patan_fold.sv =====
// patan_fold: octant and quadrant reflection, q2.13 rounding, output register
// depends on patan_pkg

`default_nettype none

module patan_fold (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [patan_pkg::RATIO_W-1:0] poly,
    input  wire patan_pkg::patan_flags_t       flags,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [patan_pkg::ANGLE_W-1:0]      angle
);
    import patan_pkg::*;

    logic               v_reg;
    logic [ANGLE_W-1:0] angle_reg;
    logic [ANGLE_W-1:0] angle_next;
    logic               en;

    logic [RATIO_W-1:0] r1;
    logic [FOLD_W-1:0]  r2;
    logic [FOLD_W:0]    r2_rnd;
    logic [QANG_W-1:0]  q13;

    assign en = !v_reg || !out_stall;
    assign in_stall = !en;

    always_comb
    begin
        r1 = flags.swap ? (HALF_PI_Q16 - poly) : poly;
        r2 = flags.xneg ? (PI_Q16 - FOLD_W'(r1)) : FOLD_W'(r1);
        r2_rnd = {1'b0, r2} + Q13_RND;
        q13 = r2_rnd[FOLD_W-1:3];
        if (flags.zero)
        begin
            angle_next = '0;
        end
        else if (flags.yneg)
        begin
            angle_next = ANGLE_W'(0) - {1'b0, q13};
        end
        else
        begin
            angle_next = {1'b0, q13};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            angle_reg <= angle_next;
        end
    end

    assign out_valid = v_reg;
    assign angle     = angle_reg;

endmodule

`default_nettype wire
